/* hdl/point_project_and_cull_macros.svh */
// Assertion helpers used by the checker file.
`ifndef POINT_PROJECT_AND_CULL_MACROS_SVH
`define POINT_PROJECT_AND_CULL_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PPC_ASSERT_SAME(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("point_project_and_cull check failed");

// Next-cycle implication, disabled while in reset.
`define PPC_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("point_project_and_cull check failed");

`endif

/* hdl/ppc_pkg.sv */
package ppc_pkg;

	localparam int CATEGORY_COUNT = 24;
	localparam int MASK_W = 24;

	// internal widths
	localparam int VW = 34;    // view space, 12 fraction bits
	localparam int PW = 50;    // one projection product
	localparam int CW = 52;    // clip space, 24 fraction bits
	localparam int AW = 53;    // cx+cw, cw-cy, 2cw
	localparam int NW = 66;    // scaled numerator
	localparam int DW = 34;    // distance difference
	localparam int RGW = 28;   // range with 12 fraction bits
	localparam int SQW = 56;
	localparam int SSW = 58;
	localparam int RW = 69;    // divider remainder
	localparam int QW = 16;    // quotient bits
	localparam int DIV_STAGES = QW + 1;

	localparam logic [63:0] SCREEN_RESET = 64'h0000_001F_4043_8780;

	typedef enum logic [2:0] {
		ST_KEPT     = 3'd0,
		ST_HIDDEN   = 3'd1,
		ST_CATEGORY = 3'd2,
		ST_BEHIND   = 3'd3,
		ST_RANGE    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		REG_VIEW_X = 4'd0,
		REG_VIEW_Y = 4'd1,
		REG_VIEW_Z = 4'd2,
		REG_VIEW_W = 4'd3,
		REG_PROJ_X = 4'd4,
		REG_PROJ_Y = 4'd5,
		REG_PROJ_W = 4'd6,
		REG_SCREEN = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0]        marker_id;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic               shown;
		logic [4:0]         category;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        result_id;
		logic [2:0]         status;
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic [15:0]        clip_depth;
	} out_item_t;

	typedef struct packed {
		logic [3:0][63:0] view;
		logic [2:0][63:0] proj;
		logic [63:0]      screen;
	} cfg_t;

	typedef struct packed {
		logic [15:0] marker_id;
		status_t     status;
		logic [15:0] depth;
	} side_t;

	typedef struct packed {
		logic          neg;
		logic          ovf;
		logic [NW-1:0] mag;
		logic [AW-1:0] den;
	} div_op_t;

	typedef struct packed {
		side_t   side;
		div_op_t op_x;
		div_op_t op_y;
	} front_out_t;

	function automatic logic signed [15:0] fld(input logic [63:0] row, input logic [1:0] k);
		return row[16*k +: 16];
	endfunction

endpackage

/* hdl/ppc_front.sv */
module ppc_front #(
	parameter int CATEGORY_COUNT = ppc_pkg::CATEGORY_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  ppc_pkg::in_item_t    in_data,
	input  ppc_pkg::cfg_t        cfg,
	output logic                 out_valid,
	output ppc_pkg::front_out_t  out_data
);
	import ppc_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;

	logic signed [15:0] pos_in [3];
	logic signed [31:0] vp_s1 [4][3];
	logic signed [15:0] vt_s1 [4];
	logic signed [31:0] cp_s1 [3][3];
	logic signed [15:0] pos_s1 [3];

	logic signed [VW-1:0] v_s2 [4];
	logic signed [VW-1:0] cam_s2 [3];
	logic signed [15:0]   pos_s2 [3];

	logic signed [PW-1:0] pp_s3 [3][4];
	logic [RGW-1:0]       dcl_s3 [3];
	logic [2:0]           big_s3;

	logic signed [CW-1:0] c_s4 [3];
	logic [SQW-1:0]       sq_s4 [3];
	logic [SQW-1:0]       rr_s4;
	logic                 big_s4;

	logic signed [AW-1:0] ax_s5, ay_s5;
	logic [AW-1:0]        den_s5;

	logic signed [NW-1:0] nx_s6, ny_s6;
	logic [AW-1:0]        den_s6;

	logic [MASK_W-1:0]    mask_sh;
	logic [RGW-1:0]       range_r;
	logic [11:0]          width, height;
	logic signed [DW-1:0] diff [3];
	logic [DW-1:0]        dmag [3];
	logic [SSW-1:0]       sumsq;
	logic                 far;
	logic [CW-25:0]       cw_hi;

	assign pos_in[0] = in_data.pos_x;
	assign pos_in[1] = in_data.pos_y;
	assign pos_in[2] = in_data.pos_z;
	assign mask_sh = MASK_W'(cfg.screen[63:40] >> in_data.category);
	assign range_r = {cfg.screen[39:24], 12'd0};
	assign width = cfg.screen[11:0];
	assign height = cfg.screen[23:12];

	// advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// stage 1: view and camera products, early rejects
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.marker_id <= in_data.marker_id;
			side_s1.depth <= 16'd0;
			if (!in_data.shown)
				side_s1.status <= ST_HIDDEN;
			else if (32'(in_data.category) < CATEGORY_COUNT && mask_sh[0])
				side_s1.status <= ST_CATEGORY;
			else
				side_s1.status <= ST_KEPT;
			for (int r = 0; r < 4; r++) begin
				for (int k = 0; k < 3; k++)
					vp_s1[r][k] <= fld(cfg.view[r], 2'(k)) * pos_in[k];
				vt_s1[r] <= fld(cfg.view[r], 2'd3);
			end
			for (int a = 0; a < 3; a++) begin
				for (int r = 0; r < 3; r++)
					cp_s1[a][r] <= fld(cfg.view[r], 2'(a)) * fld(cfg.view[r], 2'd3);
				pos_s1[a] <= pos_in[a];
			end
		end
	end

	// stage 2: view-space sums and camera position
	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			for (int r = 0; r < 4; r++)
				v_s2[r] <= VW'(vp_s1[r][0]) + VW'(vp_s1[r][1]) + VW'(vp_s1[r][2])
					+ (VW'(vt_s1[r]) <<< 12);
			for (int a = 0; a < 3; a++) begin
				cam_s2[a] <= -(VW'(cp_s1[a][0]) + VW'(cp_s1[a][1]) + VW'(cp_s1[a][2]));
				pos_s2[a] <= pos_s1[a];
			end
		end
	end

	// distance from camera per axis
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			diff[a] = (DW'(pos_s2[a]) <<< 12) - cam_s2[a];
			dmag[a] = diff[a][DW-1] ? DW'(-diff[a]) : DW'(diff[a]);
		end
	end

	// stage 3: projection products, clamp distances to range
	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			for (int j = 0; j < 3; j++)
				for (int k = 0; k < 4; k++)
					pp_s3[j][k] <= fld(cfg.proj[j], 2'(k)) * v_s2[k];
			for (int a = 0; a < 3; a++) begin
				big_s3[a] <= dmag[a] > DW'(range_r);
				dcl_s3[a] <= (dmag[a] > DW'(range_r)) ? range_r : dmag[a][RGW-1:0];
			end
		end
	end

	// stage 4: clip sums and squares
	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			for (int j = 0; j < 3; j++)
				c_s4[j] <= CW'(pp_s3[j][0]) + CW'(pp_s3[j][1])
					+ CW'(pp_s3[j][2]) + CW'(pp_s3[j][3]);
			for (int a = 0; a < 3; a++)
				sq_s4[a] <= SQW'(dcl_s3[a]) * SQW'(dcl_s3[a]);
			rr_s4 <= SQW'(range_r) * SQW'(range_r);
			big_s4 <= |big_s3;
		end
	end

	assign sumsq = SSW'(sq_s4[0]) + SSW'(sq_s4[1]) + SSW'(sq_s4[2]);
	assign far = big_s4 || (sumsq > SSW'(rr_s4));
	assign cw_hi = c_s4[2][CW-1:24];

	// stage 5: resolve status, depth, divider operands
	always_ff @(posedge clk) begin
		if (en) begin
			side_s5.marker_id <= side_s4.marker_id;
			side_s5.depth <= 16'd0;
			if (side_s4.status != ST_KEPT)
				side_s5.status <= side_s4.status;
			else if (c_s4[2] <= 0)
				side_s5.status <= ST_BEHIND;
			else if (far)
				side_s5.status <= ST_RANGE;
			else begin
				side_s5.status <= ST_KEPT;
				side_s5.depth <= (cw_hi > (CW-24)'(16'hFFFF)) ? 16'hFFFF : cw_hi[15:0];
			end
			ax_s5 <= AW'(c_s4[0]) + AW'(c_s4[2]);
			ay_s5 <= AW'(c_s4[2]) - AW'(c_s4[1]);
			den_s5 <= {c_s4[2], 1'b0};
		end
	end

	// stage 6: scale by viewport size
	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= side_s5;
			nx_s6 <= ax_s5 * $signed({1'b0, width});
			ny_s6 <= ay_s5 * $signed({1'b0, height});
			den_s6 <= den_s5;
		end
	end

	// stage 7: sign, magnitude and overflow check
	always_ff @(posedge clk) begin
		if (en) begin
			out_data.side <= side_s6;
			out_data.op_x.neg <= nx_s6[NW-1];
			out_data.op_x.mag <= nx_s6[NW-1] ? NW'(-nx_s6) : NW'(nx_s6);
			out_data.op_x.ovf <= RW'(nx_s6[NW-1] ? NW'(-nx_s6) : NW'(nx_s6))
				>= (RW'(den_s6) << QW);
			out_data.op_x.den <= den_s6;
			out_data.op_y.neg <= ny_s6[NW-1];
			out_data.op_y.mag <= ny_s6[NW-1] ? NW'(-ny_s6) : NW'(ny_s6);
			out_data.op_y.ovf <= RW'(ny_s6[NW-1] ? NW'(-ny_s6) : NW'(ny_s6))
				>= (RW'(den_s6) << QW);
			out_data.op_y.den <= den_s6;
		end
	end

	assign out_valid = vld_s7;

endmodule

/* hdl/ppc_div.sv */
module ppc_div (
	input  logic               clk,
	input  logic               en,
	input  ppc_pkg::div_op_t   op,
	output logic signed [15:0] coord
);
	import ppc_pkg::*;

	logic [RW-1:0] rem_in [0:QW-1];
	logic [QW-1:0] q_in [0:QW-1];
	logic [AW-1:0] den_in [0:QW-1];
	logic          neg_in [0:QW-1];
	logic          ovf_in [0:QW-1];

	logic [RW-1:0] rem_s [1:QW];
	logic [QW-1:0] q_s [1:QW];
	logic [AW-1:0] den_s [1:QW];
	logic          neg_s [1:QW];
	logic          ovf_s [1:QW];

	logic [QW:0]   fq;
	logic          rem_nz;

	assign rem_in[0] = RW'(op.mag);
	assign q_in[0] = '0;
	assign den_in[0] = op.den;
	assign neg_in[0] = op.neg;
	assign ovf_in[0] = op.ovf;

	// one restoring step per stage, quotient msb first
	for (genvar k = 0; k < QW; k++) begin : g_step
		if (k > 0) begin : g_link
			assign rem_in[k] = rem_s[k];
			assign q_in[k] = q_s[k];
			assign den_in[k] = den_s[k];
			assign neg_in[k] = neg_s[k];
			assign ovf_in[k] = ovf_s[k];
		end
		logic [RW-1:0] trial;
		logic          ge;
		assign trial = RW'(den_in[k]) << (QW - 1 - k);
		assign ge = rem_in[k] >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rem_in[k] - trial : rem_in[k];
				q_s[k+1] <= {q_in[k][QW-2:0], ge};
				den_s[k+1] <= den_in[k];
				neg_s[k+1] <= neg_in[k];
				ovf_s[k+1] <= ovf_in[k];
			end
		end
	end

	// floor for negative numerators, then saturate
	assign rem_nz = rem_s[QW] != '0;
	assign fq = {1'b0, q_s[QW]} + (QW+1)'(rem_nz);

	always_ff @(posedge clk) begin
		if (en) begin
			if (!neg_s[QW])
				coord <= (ovf_s[QW] || q_s[QW][QW-1]) ? 16'sh7FFF : $signed(q_s[QW]);
			else if (ovf_s[QW] || fq > (QW+1)'(17'd32768))
				coord <= 16'sh8000;
			else
				coord <= $signed(QW'((QW+1)'(0) - fq));
		end
	end

endmodule

/* hdl/point_project_and_cull.sv */
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | in_data (in_item_t)
// out     | output    | out_valid / out_ready | out_data (out_item_t)
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item enters per cycle while in_ready is high, that is while no result waits at the output.
// The pipeline is 7 transform stages plus 17 divider stages (16 quotient bits, one output stage).
// arst_n clears all valid bits and loads the configuration reset values.
// A result held at the output stalls the whole pipeline; nothing is lost.
// Configuration writes are always taken.
module point_project_and_cull #(
	parameter int CATEGORY_COUNT = ppc_pkg::CATEGORY_COUNT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ppc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ppc_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [3:0]          cfg_index,
	input  logic [63:0]         cfg_data
);
	import ppc_pkg::*;

	cfg_t       cfg_q;
	logic       en;
	logic       front_valid;
	front_out_t front_data;
	logic signed [15:0] coord_x, coord_y;

	logic  vld_s [1:DIV_STAGES];
	side_t side_s [1:DIV_STAGES];

	assign en = !vld_s[DIV_STAGES] || out_ready;
	assign in_ready = en;
	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.view <= '0;
			cfg_q.proj <= '0;
			cfg_q.screen <= SCREEN_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_VIEW_X: cfg_q.view[0] <= cfg_data;
				REG_VIEW_Y: cfg_q.view[1] <= cfg_data;
				REG_VIEW_Z: cfg_q.view[2] <= cfg_data;
				REG_VIEW_W: cfg_q.view[3] <= cfg_data;
				REG_PROJ_X: cfg_q.proj[0] <= cfg_data;
				REG_PROJ_Y: cfg_q.proj[1] <= cfg_data;
				REG_PROJ_W: cfg_q.proj[2] <= cfg_data;
				REG_SCREEN: cfg_q.screen <= cfg_data;
				default: ;
			endcase
		end
	end

	ppc_front #(
		.CATEGORY_COUNT (CATEGORY_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.out_valid (front_valid),
		.out_data  (front_data)
	);

	ppc_div u_div_x (
		.clk   (clk),
		.en    (en),
		.op    (front_data.op_x),
		.coord (coord_x)
	);

	ppc_div u_div_y (
		.clk   (clk),
		.en    (en),
		.op    (front_data.op_y),
		.coord (coord_y)
	);

	// carry valid bits alongside the divider stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= DIV_STAGES; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= front_valid;
			for (int k = 2; k <= DIV_STAGES; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	// carry id, status and depth alongside the divider stages
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= front_data.side;
			for (int k = 2; k <= DIV_STAGES; k++)
				side_s[k] <= side_s[k-1];
		end
	end

	// drop coordinates of rejected items
	assign out_valid = vld_s[DIV_STAGES];
	assign out_data.result_id = side_s[DIV_STAGES].marker_id;
	assign out_data.status = side_s[DIV_STAGES].status;
	assign out_data.screen_x = (side_s[DIV_STAGES].status == ST_KEPT) ? coord_x : 16'sd0;
	assign out_data.screen_y = (side_s[DIV_STAGES].status == ST_KEPT) ? coord_y : 16'sd0;
	assign out_data.clip_depth = side_s[DIV_STAGES].depth;

endmodule

/* hdl/ppc_checker.sv */
`include "point_project_and_cull_macros.svh"

module ppc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input ppc_pkg::out_item_t out_data
);
	import ppc_pkg::*;

	// held result keeps its payload
	`PPC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// rejected items carry no coordinates or depth
	`PPC_ASSERT_SAME(a_reject_zero, clk, arst_n, out_valid && out_data.status != ST_KEPT, out_data.screen_x == 16'sd0 && out_data.screen_y == 16'sd0 && out_data.clip_depth == 16'd0)

	// input side stalls only behind a waiting result
	`PPC_ASSERT_SAME(a_stall_rule, clk, arst_n, 1'b1, in_ready == (!out_valid || out_ready))

	// status stays within its codes
	`PPC_ASSERT_SAME(a_status_code, clk, arst_n, out_valid, out_data.status <= ST_RANGE)

endmodule

bind point_project_and_cull ppc_checker u_checker (.*);
